// ===== design/fbfl_pkg.sv =====
// Shared types, constants and helper functions of the free-list block allocator.
package fbfl_pkg;

  localparam int BLOCKS = 256;
  localparam int IDX_W  = 8;
  localparam int LINK_W = 9;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(BLOCKS);

  localparam logic [8:0] POOL_COUNT_RESET = 9'd256;
  localparam logic       REG_POOL_COUNT   = 1'b0;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_ALLOC
  } fbfl_state_t;

  typedef struct packed {
    logic release_wr;
    logic pop;
  } fbfl_cmd_t;

  // Clamp a written count into the range 1..BLOCKS.
  function automatic logic [LINK_W-1:0] clamp_count(input logic [8:0] value);
    logic [LINK_W-1:0] result;
    if (value == 9'd0) begin
      result = LINK_W'(1);
    end else if ({1'b0, value} > 10'(BLOCKS)) begin
      result = NULL_LINK;
    end else begin
      result = LINK_W'(value);
    end
    return result;
  endfunction

  // Link an entry holds before any release has written it.
  function automatic logic [LINK_W-1:0] default_link(input logic [IDX_W-1:0] idx,
                                                     input logic [LINK_W-1:0] used);
    logic [LINK_W-1:0] succ;
    succ = {1'b0, idx} + LINK_W'(1);
    return (succ < used) ? succ : NULL_LINK;
  endfunction

endpackage

// ===== design/fixed_block_free_list_allocator_top.sv =====
// Top level of the fixed-block free-list allocator.
//
// Manages 256 equal blocks as a last-in-first-out list of free block indices.
// Request channel: drive start with req_type and release_index; the word is
// taken at the clock edge where start is high and busy is low.
//   - allocate (req_type 0): the head's link comes out of the link memory's
//     registered read port in the cycle after the word is taken; done then
//     strobes for exactly one cycle with granted and block_index, and busy
//     is high for that cycle. Empty pool: granted 0, block_index 0.
//   - release (req_type 1): no result word. The index becomes the new head;
//     an index at or above the pool count in use is dropped.
// Sustained rate: one release every cycle; an allocate holds off the next word.
// The result channel has no back pressure: take done when it strobes.
// Configuration: APB register pool_count at byte address 0 (pready always
// high). A write rebuilds the list at once (head back to block 0) through
// per-entry written bits, so no clearing pass is needed. Write only while idle.
// Reset (synchronous, rst high): pool_count 256, full list, state idle.
module fixed_block_free_list_allocator_top
  import fbfl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             req_type,
  input  logic [IDX_W-1:0] release_index,
  output logic             busy,
  output logic             done,
  output logic             granted,
  output logic [IDX_W-1:0] block_index,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  fbfl_cmd_t  cmd;
  logic       cfg_load;
  logic [8:0] pool_count;

  // Register decode: bit 2 picks the register word, the low bits are byte lanes.
  assign pready   = 1'b1;
  assign cfg_load = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_COUNT);
  assign prdata   = (paddr[2] == REG_POOL_COUNT) ? {23'd0, pool_count} : 32'd0;

  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .busy     (busy),
    .done     (done),
    .cmd      (cmd)
  );

  fbfl_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_load      (cfg_load),
    .cfg_value     (pwdata[8:0]),
    .release_index (release_index),
    .pool_count    (pool_count),
    .granted       (granted),
    .block_index   (block_index)
  );

endmodule

// ===== design/fbfl_ctrl.sv =====
// Controller state machine of the free-list block allocator.
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      req_type,
  output logic      busy,
  output logic      done,
  output fbfl_cmd_t cmd
);

  fbfl_state_t state;
  fbfl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    busy           = 1'b0;
    done           = 1'b0;
    cmd.release_wr = 1'b0;
    cmd.pop        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_RELEASE) begin
            cmd.release_wr = 1'b1;
          end else begin
            state_next = ST_ALLOC;
          end
        end
      end
      ST_ALLOC: begin
        // link of the head is now out of the memory: deliver and pop
        busy       = 1'b1;
        done       = 1'b1;
        cmd.pop    = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/fbfl_datapath.sv =====
// Datapath of the free-list block allocator: link memory, valid bits, head and count.
module fbfl_datapath
  import fbfl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  fbfl_cmd_t        cmd,
  input  logic             cfg_load,
  input  logic [8:0]       cfg_value,
  input  logic [IDX_W-1:0] release_index,
  output logic [8:0]       pool_count,
  output logic             granted,
  output logic [IDX_W-1:0] block_index
);

  logic [LINK_W-1:0] link_mem [BLOCKS];
  logic [LINK_W-1:0] rd_data;
  logic [BLOCKS-1:0] written;
  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] used;
  logic              rel_ok;
  logic              head_null;
  logic [IDX_W-1:0]  head_idx;
  logic [LINK_W-1:0] pop_link;

  assign rel_ok    = cmd.release_wr && ({1'b0, release_index} < used);
  assign head_null = head[LINK_W-1];
  assign head_idx  = head[IDX_W-1:0];
  assign pop_link  = written[head_idx] ? rd_data : default_link(head_idx, used);

  // Read the head's link every cycle; it is ready when the pop comes.
  always_ff @(posedge clk) begin
    if (rel_ok) begin
      link_mem[release_index] <= head;
    end
    rd_data <= link_mem[head_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count <= POOL_COUNT_RESET;
      used       <= clamp_count(POOL_COUNT_RESET);
      head       <= '0;
      written    <= '0;
    end else if (cfg_load) begin
      pool_count <= cfg_value;
      used       <= clamp_count(cfg_value);
      head       <= '0;
      written    <= '0;
    end else if (rel_ok) begin
      written[release_index] <= 1'b1;
      head                   <= {1'b0, release_index};
    end else if (cmd.pop && !head_null) begin
      head <= pop_link;
    end
  end

  assign granted     = !head_null;
  assign block_index = head_null ? '0 : head_idx;

endmodule

// ===== design/fbfl_checker.sv =====
// Port-level checker of the free-list block allocator and its bind.
module fbfl_checker
  import fbfl_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             req_type,
  input logic             busy,
  input logic             done,
  input logic             granted,
  input logic [IDX_W-1:0] block_index
);

  // allocate word yields a result on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (!rst && start && !busy && (req_type == REQ_ALLOC)) |=> done)
    else $error("allocate gave no result");

  // release word yields no result
  assert property (@(posedge clk) disable iff (rst)
    (!rst && start && !busy && (req_type == REQ_RELEASE)) |=> !done)
    else $error("release gave a result");

  // results never come back to back
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back-to-back results");

  // no new word is taken while a result shows
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result without busy");

  // empty pool reports index zero
  assert property (@(posedge clk) disable iff (rst)
    (done && !granted) |-> (block_index == '0))
    else $error("nonzero index on empty pool");

endmodule

bind fixed_block_free_list_allocator_top fbfl_checker u_fbfl_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .req_type    (req_type),
  .busy        (busy),
  .done        (done),
  .granted     (granted),
  .block_index (block_index)
);

// ===== test/fbfl_alloc_checker.sv =====
// Scoreboard for the free-list allocator: predicts grant words and checks them.
module fbfl_alloc_checker
  import fbfl_pkg::*;
#(
  parameter logic [2:0] CFG_ADDR = 3'd0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             req_type,
  input  logic [IDX_W-1:0] release_index,
  input  logic             done,
  input  logic             granted,
  input  logic [IDX_W-1:0] block_index,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output int               fail_count,
  output int               grants_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] block_index;
  } grant_word_t;

  grant_word_t       grant_q[$];
  logic [LINK_W-1:0] link_mem[BLOCKS];
  logic [LINK_W-1:0] head_blk;
  logic [LINK_W-1:0] live_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  // Chain blocks in use to successors; the last and all above get the null link.
  function automatic void rebuild_free_list(input logic [8:0] value);
    int n;
    n = int'(value);
    if (n == 0) n = 1;
    if (n > BLOCKS) n = BLOCKS;
    live_count = LINK_W'(n);
    for (int i = 0; i < BLOCKS; i++) begin
      link_mem[i] = (i + 1 < n) ? LINK_W'(i + 1) : NULL_LINK;
    end
    head_blk = '0;
  endfunction

  // Push on release, pop on allocate; only allocate yields a grant word.
  function automatic void apply_request(input logic req, input logic [IDX_W-1:0] idx);
    grant_word_t w;
    if (req == REQ_RELEASE) begin
      if ({1'b0, idx} < live_count) begin
        link_mem[idx] = head_blk;
        head_blk      = {1'b0, idx};
      end
    end else if (head_blk == NULL_LINK) begin
      w = '{granted: 1'b0, block_index: '0};
      grant_q.push_back(w);
    end else begin
      w = '{granted: 1'b1, block_index: head_blk[IDX_W-1:0]};
      grant_q.push_back(w);
      head_blk = link_mem[head_blk[IDX_W-1:0]];
    end
  endfunction

  always @(posedge clk) begin
    grant_word_t exp_w;
    if (rst) begin
      rebuild_free_list(POOL_COUNT_RESET);
      grant_q.delete();
    end else begin
      if (done) begin
        if (grant_q.size() == 0) begin
          report_mismatch($sformatf("unexpected grant word: granted %b block_index %0d",
                                    granted, block_index));
        end else begin
          exp_w = grant_q.pop_front();
          if (granted !== exp_w.granted) begin
            report_mismatch($sformatf("granted %b, expected %b", granted, exp_w.granted));
          end
          if (block_index !== exp_w.block_index) begin
            report_mismatch($sformatf("block_index %0d, expected %0d",
                                      block_index, exp_w.block_index));
          end
        end
      end
      if (start && !busy) begin
        apply_request(req_type, release_index);
      end
      if (psel && penable && pwrite && pready && paddr == CFG_ADDR) begin
        rebuild_free_list(pwdata[8:0]);
      end
    end
    grants_owed <= grant_q.size();
  end

endmodule

// ===== test/tb_fixed_block_free_list_allocator_top.sv =====
// Stimulus, watchdog and verdict for the free-list allocator regression.
module tb_fixed_block_free_list_allocator_top
  import fbfl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Byte address of pool_count on the APB port.
  localparam logic [2:0] POOL_COUNT_ADDR = 3'(4 * REG_POOL_COUNT);
  // Idle cycles to let a release finish before touching the register.
  localparam int LATENCY_TAIL   = 3;
  // Cycles with no accepted word before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 200;
  localparam int NUM_PHASES     = 9;
  localparam int WORDS_PER_PHASE = 50;

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             start         = 1'b0;
  logic             req_type      = REQ_ALLOC;
  logic [IDX_W-1:0] release_index = '0;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [2:0]       paddr         = '0;
  logic [31:0]      pwdata        = '0;
  logic             busy;
  logic             done;
  logic             granted;
  logic [IDX_W-1:0] block_index;
  logic [31:0]      prdata;
  logic             pready;

  int fail_count;
  int grants_owed;

  // Blocks currently handed out, so releases can return real allocations.
  logic [IDX_W-1:0] held_blocks[$];
  logic             idle_on = 1'b1;
  int               alloc_words;
  int               release_words;
  int               cfg_writes;
  int               empty_grants;
  int               quiet_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fixed_block_free_list_allocator_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req_type     (req_type),
    .release_index(release_index),
    .busy         (busy),
    .done         (done),
    .granted      (granted),
    .block_index  (block_index),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  fbfl_alloc_checker #(.CFG_ADDR(POOL_COUNT_ADDR)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .release_index(release_index),
    .done         (done),
    .granted      (granted),
    .block_index  (block_index),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .grants_owed  (grants_owed)
  );

  // Track granted blocks for release picks, and count empty-pool answers.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (granted) held_blocks.push_back(block_index);
      else empty_grants++;
    end
  end

  // Watchdog: reset the count on any accepted word, request, result or register write.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("fixed_block_free_list_allocator_top regression: fail");
        $finish;
      end
    end
  end

  // Present one request word and hold it until the block takes it. Occasionally
  // drop start first for a short gap between words.
  task automatic send_word(input logic req, input logic [IDX_W-1:0] idx);
    if (idle_on && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start         <= 1'b1;
    req_type      <= req;
    release_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req == REQ_ALLOC) alloc_words++;
    else release_words++;
  endtask

  // Drop start and wait until every grant word is back, then let a trailing
  // release drain before the register may be touched.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (grants_owed != 0) @(posedge clk);
    repeat (LATENCY_TAIL) @(posedge clk);
  endtask

  // APB write of pool_count; upper data bits are random and must be ignored.
  task automatic write_pool_count(input logic [8:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= POOL_COUNT_ADDR;
    pwdata  <= {23'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    held_blocks.delete();
    cfg_writes++;
  endtask

  // Random mix: mostly allocates and returns of held blocks, plus stray
  // in-range releases (double frees) and indices that may be out of range.
  task automatic run_phase(input logic [8:0] value, input int alloc_pct, input int n_words);
    int roll;
    int pick;
    int used;
    write_pool_count(value);
    used = int'(value);
    if (used == 0) used = 1;
    if (used > BLOCKS) used = BLOCKS;
    for (int k = 0; k < n_words; k++) begin
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
        send_word(REQ_ALLOC, IDX_W'($urandom));
      end else if (roll < 90 && held_blocks.size() > 0) begin
        pick = $urandom_range(held_blocks.size() - 1);
        send_word(REQ_RELEASE, held_blocks[pick]);
        held_blocks.delete(pick);
      end else if (roll < 95) begin
        send_word(REQ_RELEASE, IDX_W'($urandom_range(used - 1)));
      end else begin
        send_word(REQ_RELEASE, IDX_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [8:0] phase_count[NUM_PHASES];
    int         phase_alloc[NUM_PHASES];
    phase_count = '{9'd2, 9'd511, 9'd3, 9'd1, 9'd0, 9'd16, 9'd40, 9'd256, 9'd5};
    phase_alloc = '{55, 52, 55, 60, 60, 55, 80, 50, 55};
    phase_count[6] = 9'($urandom_range(300, 20));

    // Hold reset at the start, then release it for good.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full pool after reset, pops in order, pushes at both ends of
    // the index range, then a double release that makes the list loop.
    send_word(REQ_ALLOC, 8'hFF);
    send_word(REQ_ALLOC, 8'h00);
    send_word(REQ_ALLOC, 8'hA5);
    send_word(REQ_RELEASE, 8'd255);
    send_word(REQ_RELEASE, 8'd0);
    send_word(REQ_ALLOC, 8'h5A);
    send_word(REQ_ALLOC, 8'h00);
    send_word(REQ_ALLOC, 8'hFF);
    send_word(REQ_RELEASE, 8'd2);
    send_word(REQ_RELEASE, 8'd2);
    send_word(REQ_ALLOC, 8'h00);
    send_word(REQ_ALLOC, 8'h00);

    // Single-block pool: empty answers and out-of-range releases that must be dropped.
    write_pool_count(9'd1);
    send_word(REQ_ALLOC, 8'h00);
    send_word(REQ_ALLOC, 8'h00);
    send_word(REQ_RELEASE, 8'd1);
    send_word(REQ_ALLOC, 8'h00);
    send_word(REQ_RELEASE, 8'd0);
    send_word(REQ_ALLOC, 8'h00);
    send_word(REQ_RELEASE, 8'd255);
    send_word(REQ_ALLOC, 8'h00);

    // A zero count acts as one block.
    write_pool_count(9'd0);
    send_word(REQ_ALLOC, 8'h00);
    send_word(REQ_ALLOC, 8'h00);

    // An oversized count saturates at the full pool.
    write_pool_count(9'd511);
    send_word(REQ_RELEASE, 8'd128);
    send_word(REQ_ALLOC, 8'h00);
    send_word(REQ_ALLOC, 8'h00);

    // Random phases over several pool sizes; one phase runs with no gaps at all.
    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_on = (p != 2);
      run_phase(phase_count[p], phase_alloc[p], WORDS_PER_PHASE);
    end

    settle();
    repeat (LATENCY_TAIL) @(posedge clk);

    $display("covered %0d allocates (%0d answered empty) and %0d releases",
             alloc_words, empty_grants, release_words);
    $display("across %0d pool_count writes, including 0, 1, 2 and 511", cfg_writes);
    if (fail_count == 0) begin
      $display("fixed_block_free_list_allocator_top regression: pass");
    end else begin
      $display("fixed_block_free_list_allocator_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/fbfl_pkg.sv
design/fbfl_ctrl.sv
design/fbfl_datapath.sv
design/fixed_block_free_list_allocator_top.sv
design/fbfl_checker.sv
test/fbfl_alloc_checker.sv
test/tb_fixed_block_free_list_allocator_top.sv
